FILE: sv/tbqm_pkg.sv
// Shared types, codes and the Fibonacci table of the TOS backoff queue mapper.
`default_nettype none
package tbqm_pkg;

  localparam logic [15:0] WIN_MAX = 16'hFFFF;
  localparam int DIV_W = 33;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CFG_STRATEGY     = 3'd0;
  localparam logic [2:0] CFG_MAPPING_MODE = 3'd1;
  localparam logic [2:0] CFG_LADDER_MODE  = 3'd2;
  localparam logic [2:0] CFG_LADDER_STEP  = 3'd3;
  localparam logic [2:0] CFG_CEILING_MODE = 3'd4;
  localparam logic [2:0] CFG_CEILING_STEP = 3'd5;

  localparam logic [1:0] STRAT_FIXED = 2'd0;
  localparam logic [1:0] STRAT_PASS  = 2'd1;
  localparam logic [1:0] STRAT_ADAPT = 2'd2;

  localparam logic [2:0] MAP_BIGGER  = 3'd0;
  localparam logic [2:0] MAP_SMALLER = 3'd1;
  localparam logic [2:0] MAP_PROB    = 3'd2;
  localparam logic [2:0] MAP_QUAD    = 3'd3;
  localparam logic [2:0] MAP_DIRECT  = 3'd4;

  localparam logic [1:0] GROW_EXP = 2'd0;
  localparam logic [1:0] GROW_MUL = 2'd1;
  localparam logic [1:0] GROW_ADD = 2'd2;
  localparam logic [1:0] GROW_FIB = 2'd3;

  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_ENTRY    = 1'b1;

  typedef enum logic [1:0] {CLS_FIXED, CLS_PASS, CLS_ADAPT} cls_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_BASE, ST_DIVW, ST_BUILD, ST_PICK,
    ST_SQL, ST_SQU, ST_MSTART, ST_MODW, ST_FINAL
  } back_state_t;

  typedef struct packed {
    logic [1:0] strategy;
    logic [2:0] mapping_mode;
    logic [1:0] ladder_mode;
    logic [3:0] ladder_step;
    logic [1:0] ceiling_mode;
    logic [3:0] ceiling_step;
  } cfg_t;

  typedef struct packed {
    cls_t        cls;
    logic [2:0]  qfix;
    logic [7:0]  tos;
    logic [15:0] want;
    logic [31:0] rnd;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  queue_index;
    logic        queue_valid;
    logic [15:0] entry_min_window;
    logic [15:0] entry_max_window;
    logic        last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [31:0]      quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [21:0] fib_val(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0: r = 22'd1;        5'd1: r = 22'd2;        5'd2: r = 22'd3;
      5'd3: r = 22'd5;        5'd4: r = 22'd8;        5'd5: r = 22'd13;
      5'd6: r = 22'd21;       5'd7: r = 22'd34;       5'd8: r = 22'd55;
      5'd9: r = 22'd89;       5'd10: r = 22'd144;     5'd11: r = 22'd233;
      5'd12: r = 22'd377;     5'd13: r = 22'd610;     5'd14: r = 22'd987;
      5'd15: r = 22'd1597;    5'd16: r = 22'd2584;    5'd17: r = 22'd4181;
      5'd18: r = 22'd6765;    5'd19: r = 22'd10946;   5'd20: r = 22'd17711;
      5'd21: r = 22'd28657;   5'd22: r = 22'd46368;   5'd23: r = 22'd75025;
      5'd24: r = 22'd121393;  5'd25: r = 22'd196418;  5'd26: r = 22'd317811;
      5'd27: r = 22'd514229;  5'd28: r = 22'd832040;  5'd29: r = 22'd1346269;
      5'd30: r = 22'd2178309; 5'd31: r = 22'd3524578;
      default: r = 22'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tbqm_front.sv
// Front end: accepts packets and classifies them by strategy.
`default_nettype none
module tbqm_front #(
  parameter int NUM_QUEUES = 4
) (
  input  tbqm_pkg::cfg_t  cfg,
  input  logic            valid,
  input  logic [7:0]      tos,
  input  logic [15:0]     desired_window,
  input  logic [31:0]     random_word,
  input  logic            full,
  output logic            push,
  output tbqm_pkg::item_t item
);
  import tbqm_pkg::*;

  logic [3:0] qi;

  always_comb begin
    case (tos)
      8'd1: qi = 4'd0;
      8'd2: qi = 4'd2;
      8'd3: qi = 4'd3;
      default: qi = 4'd1;
    endcase
    if (qi > 4'(NUM_QUEUES - 1)) qi = 4'(NUM_QUEUES - 1);

    case (cfg.strategy)
      STRAT_FIXED: item.cls = CLS_FIXED;
      STRAT_ADAPT: item.cls = CLS_ADAPT;
      default: item.cls = CLS_PASS;
    endcase
    item.qfix = qi[2:0];
    item.tos  = tos;
    item.want = desired_window;
    item.rnd  = random_word;
    push = valid && !full;
  end

endmodule
`default_nettype wire

FILE: sv/tbqm_queue.sv
// Short queue of classified packets between front and back.
`default_nettype none
module tbqm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tbqm_pkg::item_t wr_item,
  input  logic            pop,
  output logic            valid,
  output logic            full,
  output tbqm_pkg::item_t rd_item
);
  import tbqm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign valid   = count != '0;
  assign full    = count == CW'(QUEUE_DEPTH);
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: sv/tbqm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tbqm_div (
  input  logic               clk,
  input  logic               rst,
  input  tbqm_pkg::div_req_t req,
  output tbqm_pkg::div_rsp_t rsp
);
  import tbqm_pkg::*;

  logic             busy;
  logic             done_r;
  logic [4:0]       cnt;
  logic [31:0]      quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[31]};
  assign fits  = trial >= {1'b0, dvs};
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[30:0], fits};
      rem <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
    end
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/tbqm_back.sv
// Back end: window table, ladder rebuild, queue choice and result register.
`default_nettype none
module tbqm_back #(
  parameter int NUM_QUEUES     = 4,
  parameter int FIB_TABLE_SIZE = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  tbqm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  tbqm_pkg::item_t    q_item,
  output logic               q_pop,
  output tbqm_pkg::div_req_t div_req,
  input  tbqm_pkg::div_rsp_t div_rsp,
  output logic               res_valid,
  input  logic               res_stall,
  output tbqm_pkg::result_t  res
);
  import tbqm_pkg::*;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam logic [5:0] FIB_LAST = 6'(FIB_TABLE_SIZE - 1);

  back_state_t state, state_next;
  logic [15:0] min_win [NUM_QUEUES];
  logic [15:0] min_win_next [NUM_QUEUES];
  logic [7:0]  tos_r, tos_r_next;
  logic [15:0] want_r, want_r_next;
  logic [31:0] rnd_r, rnd_r_next;
  logic [15:0] w_r, w_r_next;
  logic [4:0]  fi_r, fi_r_next;
  logic [QW-1:0] bq, bq_next;
  logic [2:0]  pi_r, pi_r_next;
  logic [31:0] dl_r, dl_r_next;
  logic [31:0] du_r, du_r_next;
  logic [3:0]  pick_r, pick_r_next;
  logic        res_valid_next;
  result_t     res_next;

  // Returns {new fibonacci index, saturated window}.
  function automatic logic [20:0] grow(input logic [1:0] mode, input logic [3:0] s,
                                       input logic [15:0] w, input logic [4:0] fi);
    logic [32:0] e;
    logic [19:0] m;
    logic [16:0] a;
    logic [5:0]  k;
    logic [21:0] f;
    logic [15:0] r;
    logic [4:0]  fo;
    e = ((33'(w) + 33'd1) << s) - 33'd1;
    m = 20'(w) * 20'(s);
    a = 17'(w) + 17'(s);
    k = 6'(fi) + 6'(s);
    if (k > FIB_LAST) k = FIB_LAST;
    f = fib_val(k[4:0]);
    fo = fi;
    case (mode)
      GROW_EXP: r = (e > 33'(WIN_MAX)) ? WIN_MAX : e[15:0];
      GROW_MUL: r = (m > 20'(WIN_MAX)) ? WIN_MAX : m[15:0];
      GROW_ADD: r = (a > 17'(WIN_MAX)) ? WIN_MAX : a[15:0];
      GROW_FIB: begin
        fo = k[4:0];
        r = (f > 22'(WIN_MAX)) ? WIN_MAX : f[15:0];
      end
      default: r = w;
    endcase
    return {fo, r};
  endfunction

  always_ff @(posedge clk) begin
    tos_r  <= tos_r_next;
    want_r <= want_r_next;
    rnd_r  <= rnd_r_next;
    w_r    <= w_r_next;
    fi_r   <= fi_r_next;
    bq     <= bq_next;
    pi_r   <= pi_r_next;
    dl_r   <= dl_r_next;
    du_r   <= du_r_next;
    pick_r <= pick_r_next;
    res    <= res_next;
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) min_win[q] <= 16'((32'd16 << q) - 32'd1);
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      for (int q = 0; q < NUM_QUEUES; q++) min_win[q] <= min_win_next[q];
    end
  end

  always_comb begin
    logic        out_free;
    logic        redo;
    logic [16:0] base;
    logic [16:0] c;
    logic [21:0] wv;
    logic        found;
    logic [4:0]  idx;
    logic [4:0]  fi0;
    logic [20:0] gl;
    logic [20:0] gc;
    logic        hs;
    logic        hb;
    logic [2:0]  is_i;
    logic [2:0]  ib_i;
    logic [15:0] cdl;
    logic [15:0] cdu;
    logic signed [5:0] qs;

    state_next  = state;
    tos_r_next  = tos_r;
    want_r_next = want_r;
    rnd_r_next  = rnd_r;
    w_r_next    = w_r;
    fi_r_next   = fi_r;
    bq_next     = bq;
    pi_r_next   = pi_r;
    dl_r_next   = dl_r;
    du_r_next   = du_r;
    pick_r_next = pick_r;
    for (int q = 0; q < NUM_QUEUES; q++) min_win_next[q] = min_win[q];
    out_free       = !res_valid || !res_stall;
    res_valid_next = res_valid && res_stall;
    res_next       = res;
    q_pop          = 1'b0;
    div_req        = '0;
    redo = 1'b0;
    base = '0;
    c    = '0;
    wv   = '0;
    found = 1'b0;
    idx  = '0;
    fi0  = '0;
    gl   = '0;
    gc   = '0;
    hs   = 1'b0;
    hb   = 1'b0;
    is_i = '0;
    ib_i = '0;
    cdl  = '0;
    cdu  = '0;
    qs   = '0;

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.cls)
            CLS_ADAPT: begin
              q_pop       = 1'b1;
              tos_r_next  = q_item.tos;
              want_r_next = q_item.want;
              rnd_r_next  = q_item.rnd;
              state_next  = ST_CHECK;
            end
            CLS_FIXED: begin
              if (out_free) begin
                q_pop          = 1'b1;
                res_valid_next = 1'b1;
                res_next       = '{KIND_DECISION, q_item.qfix, 1'b1, 16'd0, 16'd0, 1'b1};
              end
            end
            default: begin
              if (out_free) begin
                q_pop          = 1'b1;
                res_valid_next = 1'b1;
                res_next       = '{KIND_DECISION, 3'd0, 1'b0, 16'd0, 16'd0, 1'b1};
              end
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (cfg.mapping_mode == MAP_DIRECT) redo = min_win[1] != want_r;
        else redo = (min_win[0] >= want_r) || (min_win[NUM_QUEUES-1] <= want_r);
        state_next = redo ? ST_BASE : ST_PICK;
      end

      ST_BASE: begin
        base = (want_r == 16'd0) ? 17'd1 : 17'(want_r);
        if (cfg.mapping_mode != MAP_DIRECT) begin
          c = 17'h10000;
          for (int k = 16; k >= 0; k--) begin
            if ((17'd1 << k) >= base) c = 17'd1 << k;
          end
          base = c;
        end
        for (int i = FIB_TABLE_SIZE - 1; i >= 0; i--) begin
          if (fib_val(5'(i)) >= 22'(want_r)) begin
            found = 1'b1;
            idx   = 5'(i);
          end
        end
        if (!found) fi0 = FIB_LAST[4:0];
        else fi0 = (idx >= 5'(cfg.ladder_step)) ? idx - 5'(cfg.ladder_step) : 5'd0;
        fi_r_next  = 5'd0;
        bq_next    = '0;
        state_next = ST_BUILD;
        case (cfg.ladder_mode)
          GROW_EXP: wv = 22'((base - 17'd1) >> cfg.ladder_step);
          GROW_MUL: begin
            wv = 22'(base);
            if (cfg.ladder_step != 4'd0) begin
              div_req.start    = 1'b1;
              div_req.dividend = 32'(base);
              div_req.divisor  = DIV_W'(cfg.ladder_step);
              state_next       = ST_DIVW;
            end
          end
          GROW_ADD: wv = (base > 17'(cfg.ladder_step)) ?
                         22'(base - 17'(cfg.ladder_step)) : 22'd0;
          default: begin
            wv        = fib_val(fi0);
            fi_r_next = fi0;
          end
        endcase
        w_r_next = (wv == 22'd0) ? 16'd1 : (wv > 22'(WIN_MAX)) ? WIN_MAX : wv[15:0];
      end

      ST_DIVW: begin
        if (div_rsp.done) begin
          w_r_next = (div_rsp.quotient == 32'd0) ? 16'd1 :
                     (div_rsp.quotient > 32'(WIN_MAX)) ? WIN_MAX : div_rsp.quotient[15:0];
          state_next = ST_BUILD;
        end
      end

      ST_BUILD: begin
        if (out_free) begin
          gc = grow(cfg.ceiling_mode, cfg.ceiling_step, w_r, fi_r);
          gl = grow(cfg.ladder_mode, cfg.ladder_step, w_r, fi_r);
          min_win_next[bq] = w_r;
          res_valid_next   = 1'b1;
          res_next         = '{KIND_ENTRY, 3'(bq), 1'b0, w_r, gc[15:0], 1'b0};
          w_r_next  = gl[15:0];
          fi_r_next = gl[20:16];
          if (bq == QW'(NUM_QUEUES - 1)) state_next = ST_PICK;
          else bq_next = bq + 1'b1;
        end
      end

      ST_PICK: begin
        for (int i = NUM_QUEUES - 2; i >= 0; i--) begin
          if (min_win[i] <= want_r && want_r < min_win[i+1]) begin
            hs   = 1'b1;
            is_i = 3'(i);
          end
          if (min_win[i] < want_r && want_r <= min_win[i+1]) begin
            hb   = 1'b1;
            ib_i = 3'(i);
            cdl  = want_r - min_win[i];
            cdu  = min_win[i+1] - want_r;
          end
        end
        state_next = ST_FINAL;
        if (want_r <= min_win[0]) begin
          pick_r_next = 4'd0;
        end else if (cfg.mapping_mode == MAP_SMALLER || cfg.mapping_mode == MAP_DIRECT) begin
          pick_r_next = hs ? 4'(is_i) : 4'(NUM_QUEUES - 1);
        end else if (cfg.mapping_mode == MAP_PROB || cfg.mapping_mode == MAP_QUAD) begin
          if (hb) begin
            pi_r_next  = ib_i;
            dl_r_next  = 32'(cdl);
            du_r_next  = 32'(cdu);
            state_next = (cfg.mapping_mode == MAP_QUAD) ? ST_SQL : ST_MSTART;
          end else begin
            pick_r_next = 4'(NUM_QUEUES - 1);
          end
        end else begin
          pick_r_next = hb ? 4'(ib_i) + 4'd1 : 4'(NUM_QUEUES - 1);
        end
      end

      ST_SQL: begin
        dl_r_next  = 32'(dl_r[15:0]) * 32'(dl_r[15:0]);
        state_next = ST_SQU;
      end

      ST_SQU: begin
        du_r_next  = 32'(du_r[15:0]) * 32'(du_r[15:0]);
        state_next = ST_MSTART;
      end

      ST_MSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = rnd_r;
        div_req.divisor  = DIV_W'(dl_r) + DIV_W'(du_r);
        state_next       = ST_MODW;
      end

      ST_MODW: begin
        if (div_rsp.done) begin
          pick_r_next = (div_rsp.remainder < DIV_W'(dl_r)) ? 4'(pi_r) + 4'd1 : 4'(pi_r);
          state_next  = ST_FINAL;
        end
      end

      ST_FINAL: begin
        if (out_free) begin
          qs = $signed({2'b00, pick_r});
          case (tos_r)
            8'd1: qs = qs - 6'sd1;
            8'd2: qs = qs + 6'sd1;
            8'd3: qs = qs + 6'sd2;
            default: qs = qs;
          endcase
          if (qs > $signed(6'(NUM_QUEUES - 1))) qs = $signed(6'(NUM_QUEUES - 1));
          if (qs < 6'sd0) qs = 6'sd0;
          res_valid_next = 1'b1;
          res_next       = '{KIND_DECISION, qs[2:0], 1'b1, 16'd0, 16'd0, 1'b1};
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/tos_backoff_queue_mapper.sv
// Top level of the TOS backoff queue mapper: config registers, front, queue and back.
//
// Packets enter on the item channel (item_valid / item_stall) with their TOS value,
// desired contention window and a random word. Each packet produces one or more
// transactions on the result channel (result_valid / result_stall); the final one of
// a packet carries last. A queue decision has kind 0; a rebuilt table entry has kind 1.
// Users write configuration (cfg_we/cfg_index/cfg_data) while the block idles; unenforced.
//
// The front classifies each packet and drops it into a two-entry queue, so new packets
// are taken while the back end works. Fixed and pass packets are answered in the idle
// state. An adaptive packet goes through check, choice and result, plus a rebuild of the
// window ladder when needed (one entry per cycle while the output is free), plus a
// division through the shared serial divider for the multiply ladder, plus the
// probabilistic choice (squared distances when quadratic), whose modulo uses the divider.
// Results are held in an output register; a stalled result holds and the back end
// waits before its next result, while the front keeps filling its queue until it is full.
//
// Reset clears the queue and the result valid flag, restores the window table to
// 15, 31, 63, ... and sets the registers to their defaults.
`default_nettype none
module tos_backoff_queue_mapper #(
  parameter int NUM_QUEUES     = 4,
  parameter int FIB_TABLE_SIZE = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  tos,
  input  logic [15:0] desired_window,
  input  logic [31:0] random_word,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [2:0]  queue_index,
  output logic        queue_valid,
  output logic [15:0] entry_min_window,
  output logic [15:0] entry_max_window,
  output logic        last
);
  import tbqm_pkg::*;

  cfg_t     cfg;
  item_t    f_item;
  item_t    q_item;
  logic     push;
  logic     full;
  logic     q_valid;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  res;

  // Registers take the low bits of the write data; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{STRAT_FIXED, MAP_BIGGER, GROW_EXP, 4'd1, GROW_EXP, 4'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRATEGY:     cfg.strategy     <= cfg_data[1:0];
        CFG_MAPPING_MODE: cfg.mapping_mode <= cfg_data[2:0];
        CFG_LADDER_MODE:  cfg.ladder_mode  <= cfg_data[1:0];
        CFG_LADDER_STEP:  cfg.ladder_step  <= cfg_data;
        CFG_CEILING_MODE: cfg.ceiling_mode <= cfg_data[1:0];
        CFG_CEILING_STEP: cfg.ceiling_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item_stall = full;

  tbqm_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
    .cfg(cfg), .valid(item_valid), .tos(tos), .desired_window(desired_window),
    .random_word(random_word), .full(full), .push(push), .item(f_item)
  );

  tbqm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_item(f_item), .pop(q_pop),
    .valid(q_valid), .full(full), .rd_item(q_item)
  );

  tbqm_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  tbqm_back #(.NUM_QUEUES(NUM_QUEUES), .FIB_TABLE_SIZE(FIB_TABLE_SIZE)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .div_req(div_req), .div_rsp(div_rsp), .res_valid(result_valid),
    .res_stall(result_stall), .res(res)
  );

  assign kind             = res.kind;
  assign queue_index      = res.queue_index;
  assign queue_valid      = res.queue_valid;
  assign entry_min_window = res.entry_min_window;
  assign entry_max_window = res.entry_max_window;
  assign last             = res.last;

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the TOS backoff queue mapper.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tbqm_pkg::*;

  localparam int NQ = 4;
  localparam int FIB_END = 23;
  localparam int RANDOM_ITEMS = 310;
  localparam int PHASE_ITEMS = 31;

  // Fibonacci ladder values, one per index.
  localparam int unsigned FIB_SEQ [0:23] = '{
    1, 2, 3, 5, 8, 13, 21, 34, 55, 89, 144, 233, 377, 610, 987, 1597,
    2584, 4181, 6765, 10946, 17711, 28657, 46368, 75025};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic [7:0] tos;
  logic [15:0] desired_window;
  logic [31:0] random_word;
  logic result_valid;
  logic result_stall;
  logic kind;
  logic [2:0] queue_index;
  logic queue_valid;
  logic [15:0] entry_min_window;
  logic [15:0] entry_max_window;
  logic last;

  tos_backoff_queue_mapper u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .tos(tos), .desired_window(desired_window), .random_word(random_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .queue_index(queue_index), .queue_valid(queue_valid),
    .entry_min_window(entry_min_window), .entry_max_window(entry_max_window),
    .last(last)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Independent copy of the window table and the configuration registers.
  logic [15:0] win_min [NQ];
  logic [15:0] win_max [NQ];
  cfg_t cur_cfg;

  result_t pending_results [$];
  int error_count = 0;

  // Idle mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both at a light rate.
  int idle_mode = 0;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic longint unsigned sat16(input longint unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  // One ladder or ceiling step. The Fibonacci index advances only in Fibonacci mode.
  function automatic longint unsigned next_window(input logic [1:0] mode,
      input int unsigned s, input longint unsigned w, inout int unsigned fi);
    int unsigned k;
    case (mode)
      GROW_EXP: return sat16(((w + 1) << s) - 1);
      GROW_MUL: return sat16(w * s);
      GROW_ADD: return sat16(w + s);
      default: begin
        k = fi + s;
        if (k > FIB_END) k = FIB_END;
        fi = k;
        return sat16(FIB_SEQ[k]);
      end
    endcase
  endfunction

  function automatic void rebuild_ladder(input int unsigned want);
    longint unsigned base, w, c;
    int unsigned fi, cf, i, ls;
    ls = cur_cfg.ladder_step;
    fi = 0;
    base = (want > 0) ? want : 1;
    // Outside direct mode the base is rounded up to a power of two.
    if (cur_cfg.mapping_mode != MAP_DIRECT) begin
      c = 1;
      while (c < base) c = c << 1;
      base = c;
    end
    case (cur_cfg.ladder_mode)
      GROW_EXP: w = (base - 1) >> ls;
      GROW_MUL: w = (ls > 0) ? base / ls : base;
      GROW_ADD: w = (base > ls) ? base - ls : 0;
      default: begin
        i = 0;
        while (i <= FIB_END && FIB_SEQ[i] < want) i++;
        if (i > FIB_END) fi = FIB_END;
        else fi = (i >= ls) ? i - ls : 0;
        w = FIB_SEQ[fi];
      end
    endcase
    if (w < 1) w = 1;
    w = sat16(w);
    for (int q = 0; q < NQ; q++) begin
      cf = fi;
      win_min[q] = w[15:0];
      win_max[q] = 16'(next_window(cur_cfg.ceiling_mode, cur_cfg.ceiling_step, w, cf));
      w = next_window(cur_cfg.ladder_mode, ls, w, fi);
    end
  endfunction

  function automatic int choose_queue(input int unsigned bo, input logic [31:0] rnd);
    longint unsigned dl, du;
    logic [2:0] m;
    m = cur_cfg.mapping_mode;
    if (bo <= win_min[0]) return 0;
    if (m == MAP_SMALLER || m == MAP_DIRECT) begin
      for (int i = 0; i < NQ - 1; i++)
        if (win_min[i] <= bo && bo < win_min[i+1]) return i;
    end else if (m == MAP_PROB || m == MAP_QUAD) begin
      for (int i = 0; i < NQ - 1; i++) begin
        if (bo > win_min[i] && bo <= win_min[i+1]) begin
          dl = bo - win_min[i];
          du = win_min[i+1] - bo;
          if (m == MAP_QUAD) begin
            dl = dl * dl;
            du = du * du;
          end
          return ((longint'(rnd) % (dl + du)) < dl) ? i + 1 : i;
        end
      end
    end else begin
      // Next bigger, also taken for the unused mapping codes.
      for (int i = 0; i < NQ - 1; i++)
        if (win_min[i] < bo && bo <= win_min[i+1]) return i + 1;
    end
    return NQ - 1;
  endfunction

  // Predicts every result of one accepted packet and queues them in order.
  function automatic void map_packet(input logic [7:0] t, input logic [15:0] want,
      input logic [31:0] rnd);
    result_t r;
    int q;
    logic rebuild;
    r = '0;
    r.last = 1'b1;
    r.kind = KIND_DECISION;
    if (cur_cfg.strategy == STRAT_FIXED) begin
      q = (t == 1) ? 0 : (t == 2) ? 2 : (t == 3) ? 3 : 1;
      if (q > NQ - 1) q = NQ - 1;
      r.queue_index = q[2:0];
      r.queue_valid = 1'b1;
      pending_results.push_back(r);
      return;
    end
    if (cur_cfg.strategy != STRAT_ADAPT) begin
      pending_results.push_back(r);
      return;
    end
    if (cur_cfg.mapping_mode == MAP_DIRECT) rebuild = (win_min[1] != want);
    else rebuild = (win_min[0] >= want) || (win_min[NQ-1] <= want);
    if (rebuild) begin
      rebuild_ladder(want);
      for (int i = 0; i < NQ; i++) begin
        r = '0;
        r.kind = KIND_ENTRY;
        r.queue_index = i[2:0];
        r.entry_min_window = win_min[i];
        r.entry_max_window = win_max[i];
        pending_results.push_back(r);
      end
    end
    q = choose_queue(want, rnd);
    if (t == 1) q = q - 1;
    else if (t == 2) q = q + 1;
    else if (t == 3) q = q + 2;
    if (q > NQ - 1) q = NQ - 1;
    if (q < 0) q = 0;
    r = '0;
    r.kind = KIND_DECISION;
    r.queue_index = q[2:0];
    r.queue_valid = 1'b1;
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic bit roll_idle(input bit sender);
    case (idle_mode)
      1: return sender && ($urandom_range(99) < 87);
      2: return !sender && ($urandom_range(99) < 87);
      3: return $urandom_range(99) < 10;
      default: return 1'b0;
    endcase
  endfunction

  // Result side: check each accepted transaction, then pick the next stall value.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          exp_r = pending_results.pop_front();
          if (kind !== exp_r.kind)
            report_mismatch($sformatf("kind %0b, expected %0b", kind, exp_r.kind));
          if (queue_index !== exp_r.queue_index)
            report_mismatch($sformatf("queue_index %0d, expected %0d",
                                      queue_index, exp_r.queue_index));
          if (queue_valid !== exp_r.queue_valid)
            report_mismatch($sformatf("queue_valid %0b, expected %0b",
                                      queue_valid, exp_r.queue_valid));
          if (entry_min_window !== exp_r.entry_min_window)
            report_mismatch($sformatf("entry_min_window %0d, expected %0d",
                                      entry_min_window, exp_r.entry_min_window));
          if (entry_max_window !== exp_r.entry_max_window)
            report_mismatch($sformatf("entry_max_window %0d, expected %0d",
                                      entry_max_window, exp_r.entry_max_window));
          if (last !== exp_r.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, exp_r.last));
        end
      end
      result_stall <= roll_idle(1'b0);
    end
  end

  // Presents one packet, waits for acceptance and then predicts its results. The
  // task is entered just after a rising edge; a typed expectation replaces the
  // predictor for rows whose answer is obvious.
  task automatic send_packet(input logic [7:0] t, input logic [15:0] want,
      input logic [31:0] rnd, input bit typed, input result_t typed_r);
    if (roll_idle(1'b1)) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while (roll_idle(1'b1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    tos <= t;
    desired_window <= want;
    random_word <= rnd;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (typed) pending_results.push_back(typed_r);
    else map_packet(t, want, rnd);
  endtask

  // Registers are only written with the block drained; all six are written each time.
  task automatic load_config(input cfg_t c);
    logic [3:0] vals [6];
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    vals[CFG_STRATEGY] = c.strategy;
    vals[CFG_MAPPING_MODE] = c.mapping_mode;
    vals[CFG_LADDER_MODE] = c.ladder_mode;
    vals[CFG_LADDER_STEP] = c.ladder_step;
    vals[CFG_CEILING_MODE] = c.ceiling_mode;
    vals[CFG_CEILING_STEP] = c.ceiling_step;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  typedef struct {
    cfg_t        c;
    logic [7:0]  t;
    logic [15:0] want;
    logic [31:0] rnd;
    bit          typed;
    logic [2:0]  q;
    logic        v;
  } stim_row_t;

  function automatic cfg_t mk_cfg(input logic [1:0] s, input logic [2:0] m,
      input logic [1:0] lm, input logic [3:0] ls, input logic [1:0] cm,
      input logic [3:0] cs);
    cfg_t c;
    c.strategy = s;
    c.mapping_mode = m;
    c.ladder_mode = lm;
    c.ladder_step = ls;
    c.ceiling_mode = cm;
    c.ceiling_step = cs;
    return c;
  endfunction

  // Biases the desired window toward the current table so that both the rebuild
  // and the no-rebuild paths, and every interval of the queue search, are reached.
  function automatic logic [15:0] pick_window();
    int unsigned lo, hi;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        lo = win_min[0];
        hi = win_min[NQ-1];
        return 16'($urandom_range(hi, lo));
      end
      2: return 16'(win_min[$urandom_range(NQ-1)] + $urandom_range(2) - 1);
      default: return 16'($urandom_range(300));
    endcase
  endfunction

  initial begin
    stim_row_t rows [$];
    cfg_t dflt, c;
    result_t tr;
    int sent;
    int phase;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    tos = '0;
    desired_window = '0;
    random_word = '0;
    for (int q = 0; q < NQ; q++) begin
      win_min[q] = 16'((16 << q) - 1);
      win_max[q] = 16'd1023;
    end
    dflt = mk_cfg(STRAT_FIXED, MAP_BIGGER, GROW_EXP, 4'd1, GROW_EXP, 4'd1);
    cur_cfg = dflt;

    // Directed rows. The fixed map after reset and the pass strategy are typed in;
    // the adaptive rows cover window and random extremes and every mode.
    rows.push_back('{dflt, 8'd0, 16'd0, 32'd0, 1, 3'd1, 1'b1});
    rows.push_back('{dflt, 8'd1, 16'hFFFF, 32'hFFFFFFFF, 1, 3'd0, 1'b1});
    rows.push_back('{dflt, 8'd2, 16'd100, 32'd5, 1, 3'd2, 1'b1});
    rows.push_back('{dflt, 8'd3, 16'd7, 32'd9, 1, 3'd3, 1'b1});
    rows.push_back('{dflt, 8'd255, 16'd1, 32'd1, 1, 3'd1, 1'b1});
    c = mk_cfg(STRAT_PASS, MAP_BIGGER, GROW_EXP, 4'd1, GROW_EXP, 4'd1);
    rows.push_back('{c, 8'd2, 16'd500, 32'd3, 1, 3'd0, 1'b0});
    // Strategy code 3 behaves as pass.
    c = mk_cfg(2'd3, MAP_BIGGER, GROW_EXP, 4'd1, GROW_EXP, 4'd1);
    rows.push_back('{c, 8'd0, 16'd500, 32'd3, 1, 3'd0, 1'b0});
    c = mk_cfg(STRAT_ADAPT, MAP_BIGGER, GROW_EXP, 4'd1, GROW_EXP, 4'd1);
    rows.push_back('{c, 8'd0, 16'd0, 32'd0, 0, 3'd0, 1'b0});
    rows.push_back('{c, 8'd2, 16'hFFFF, 32'hFFFFFFFF, 0, 3'd0, 1'b0});
    rows.push_back('{c, 8'd1, 16'd1000, 32'd0, 0, 3'd0, 1'b0});
    c = mk_cfg(STRAT_ADAPT, MAP_PROB, GROW_MUL, 4'd0, GROW_ADD, 4'd15);
    rows.push_back('{c, 8'd3, 16'd300, 32'hFFFFFFFF, 0, 3'd0, 1'b0});
    rows.push_back('{c, 8'd0, 16'd200, 32'd0, 0, 3'd0, 1'b0});
    c = mk_cfg(STRAT_ADAPT, MAP_QUAD, GROW_ADD, 4'd15, GROW_MUL, 4'd0);
    rows.push_back('{c, 8'd0, 16'd40, 32'h12345678, 0, 3'd0, 1'b0});
    rows.push_back('{c, 8'd1, 16'd60, 32'h87654321, 0, 3'd0, 1'b0});
    // Direct mode rebuilds unless the second minimum matches exactly.
    c = mk_cfg(STRAT_ADAPT, MAP_DIRECT, GROW_FIB, 4'd15, GROW_FIB, 4'd15);
    rows.push_back('{c, 8'd0, 16'hFFFF, 32'd0, 0, 3'd0, 1'b0});
    rows.push_back('{c, 8'd2, 16'd0, 32'd0, 0, 3'd0, 1'b0});
    c = mk_cfg(STRAT_ADAPT, 3'd7, GROW_EXP, 4'd15, GROW_EXP, 4'd15);
    rows.push_back('{c, 8'd3, 16'd1234, 32'd77, 0, 3'd0, 1'b0});
    c = mk_cfg(STRAT_ADAPT, MAP_SMALLER, GROW_FIB, 4'd0, GROW_EXP, 4'd0);
    rows.push_back('{c, 8'd1, 16'd90, 32'd1, 0, 3'd0, 1'b0});
    rows.push_back('{c, 8'd0, 16'd20000, 32'd2, 0, 3'd0, 1'b0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].c != cur_cfg) load_config(rows[i].c);
      tr = '0;
      tr.kind = KIND_DECISION;
      tr.queue_index = rows[i].q;
      tr.queue_valid = rows[i].v;
      tr.last = 1'b1;
      send_packet(rows[i].t, rows[i].want, rows[i].rnd, rows[i].typed, tr);
    end

    // Random phases: each has its own settings and idle pattern. The first two
    // use the step extremes; most phases run the adaptive strategy.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      c.strategy = ($urandom_range(9) == 0) ? STRAT_FIXED :
                   ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : STRAT_ADAPT;
      c.mapping_mode = 3'($urandom_range(7));
      c.ladder_mode = 2'($urandom_range(3));
      c.ceiling_mode = 2'($urandom_range(3));
      c.ladder_step = (phase == 0) ? 4'd15 : (phase == 1) ? 4'd0 : 4'($urandom_range(15));
      c.ceiling_step = (phase == 0) ? 4'd15 : (phase == 1) ? 4'd0 : 4'($urandom_range(15));
      load_config(c);
      idle_mode = phase % 4;
      for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
        send_packet(($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom),
                    pick_window(), $urandom, 1'b0, tr);
        sent++;
      end
      phase++;
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
